// File: hw/rtl/u8u16_pkg.sv
// types and constants shared by the utf-8 to utf-16 transcoder modules
// no dependencies

package u8u16_pkg;

  // result kind codes
  localparam logic KIND_UNIT  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // error codes
  localparam logic [1:0] ERR_BAD_LEAD    = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED   = 2'd1;
  localparam logic [1:0] ERR_BAD_CONT    = 2'd2;

  // output mode register values
  localparam logic MODE_UTF16 = 1'b0;
  localparam logic MODE_UTF32 = 1'b1;

  // surrogate arithmetic
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] HIGH_SURR  = 21'h0D800;
  localparam logic [20:0] LOW_SURR   = 21'h0DC00;

  // one input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } byte_item_t;

  // one result word
  typedef struct packed {
    logic        kind;
    logic [20:0] code_unit;
    logic [1:0]  error_code;
    logic        last;
  } unit_item_t;

  // up to two result words produced by one byte
  typedef struct packed {
    logic       has_first;
    logic       has_second;
    unit_item_t first;
    unit_item_t second;
  } dec_res_t;

endpackage

// File: hw/rtl/utf8_to_utf16_transcoder_core.sv
// top level of the utf-8 to utf-16 / utf-32 transcoder
// depends on u8u16_pkg, u8u16_decode and u8u16_out_buf
//
// usage
// - byte channel: byte_valid / byte_stall / byte_item carry one utf-8 byte
//   per word, end_of_string set on the final byte of each string
// - unit channel: unit_valid / unit_stall / unit_item carry code units or
//   error words; last marks the final word of a string
// - cfg_we / cfg_wdata write output_mode (0 utf-16, 1 utf-32); write only
//   while the block is idle
// - a byte is held in the input register and decoded there; its first result
//   word passes through the result register onto the unit channel
// - one byte per cycle sustained while the receiver does not stall; a surrogate
//   pair fills both result entries and holds the byte channel until the result register has room again
// - bytes that give no result never wait on the receiver
// - when the receiver stalls, the two-entry result register fills and the
//   stall passes back to the byte channel; nothing is lost or repeated
// - synchronous reset clears the sequence state, the mode register (utf-16)
//   and all valid flags

module utf8_to_utf16_transcoder_core import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       unit_valid,
  input  logic       unit_stall,
  output unit_item_t unit_item
);

  logic       mode;
  logic       in_v;
  byte_item_t in_word;
  dec_res_t   res;
  logic       can_load;
  logic       advance;
  logic       take;

  // output mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UTF16;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // input register moves on when its results fit in the result register
  assign advance    = in_v && (!res.has_first || can_load);
  assign byte_stall = in_v && !advance;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (take) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word <= byte_item;
    end
  end

  // decode
  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .consume (advance),
    .item    (in_word),
    .mode    (mode),
    .res     (res)
  );

  // result register
  u8u16_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && res.has_first),
    .res        (res),
    .can_load   (can_load),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item)
  );

endmodule

// File: hw/rtl/u8u16_decode.sv
// sequence decoder: holds the per-string state and turns one byte into
// zero, one or two result words; depends on u8u16_pkg

module u8u16_decode import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       consume,
  input  byte_item_t item,
  input  logic       mode,
  output dec_res_t   res
);

  logic [20:0] acc, acc_next;
  logic [1:0]  remain, remain_next;
  logic        bad_cont, bad_cont_next;
  logic        discard, discard_next;

  logic [7:0]  b;
  logic        eos;
  logic [20:0] acc_shift;
  logic [1:0]  remain_dec;
  logic        bad_cont_upd;
  logic        emit_point;
  logic [20:0] point;
  logic [20:0] supp;

  assign b            = item.data_byte;
  assign eos          = item.end_of_string;
  assign acc_shift    = {acc[14:0], b[5:0]};
  assign remain_dec   = remain - 2'd1;
  assign bad_cont_upd = bad_cont | (b[7:6] != 2'b10);
  assign supp         = point - SUPP_BASE;

  // next state and result selection
  always_comb begin
    acc_next      = acc;
    remain_next   = remain;
    bad_cont_next = bad_cont;
    discard_next  = discard;
    emit_point    = 1'b0;
    point         = '0;
    res           = '0;

    if (discard) begin
      // dropping bytes until the end of the string
      if (eos) begin
        discard_next  = 1'b0;
        acc_next      = '0;
        remain_next   = '0;
        bad_cont_next = 1'b0;
      end
    end else if (remain == 2'd0) begin
      // lead byte
      bad_cont_next = 1'b0;
      if (b[7] == 1'b0) begin
        emit_point  = 1'b1;
        point       = {13'd0, b};
        acc_next    = '0;
      end else if (b[7:5] == 3'b110) begin
        acc_next    = {16'd0, b[4:0]};
        remain_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_next    = {17'd0, b[3:0]};
        remain_next = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_next    = {18'd0, b[2:0]};
        remain_next = 2'd3;
      end else begin
        res.has_first        = 1'b1;
        res.first.kind       = KIND_ERROR;
        res.first.error_code = ERR_BAD_LEAD;
        res.first.last       = 1'b1;
        acc_next             = '0;
        remain_next          = '0;
        discard_next         = !eos;
      end
      // string ends right after a multi-byte lead
      if (eos && remain_next != 2'd0) begin
        res.has_first        = 1'b1;
        res.first.kind       = KIND_ERROR;
        res.first.error_code = ERR_TRUNCATED;
        res.first.last       = 1'b1;
        acc_next             = '0;
        remain_next          = '0;
      end
    end else begin
      // continuation byte
      acc_next      = acc_shift;
      remain_next   = remain_dec;
      bad_cont_next = bad_cont_upd;
      if (remain_dec != 2'd0) begin
        if (eos) begin
          res.has_first        = 1'b1;
          res.first.kind       = KIND_ERROR;
          res.first.error_code = ERR_TRUNCATED;
          res.first.last       = 1'b1;
          acc_next             = '0;
          remain_next          = '0;
          bad_cont_next        = 1'b0;
        end
      end else if (bad_cont_upd) begin
        res.has_first        = 1'b1;
        res.first.kind       = KIND_ERROR;
        res.first.error_code = ERR_BAD_CONT;
        res.first.last       = 1'b1;
        acc_next             = '0;
        bad_cont_next        = 1'b0;
        discard_next         = !eos;
      end else begin
        emit_point    = 1'b1;
        point         = acc_shift;
        acc_next      = '0;
        bad_cont_next = 1'b0;
      end
    end

    // code point to utf-32 or utf-16 words
    if (emit_point) begin
      res.has_first = 1'b1;
      if (mode == MODE_UTF32 || point[20:16] == 5'd0) begin
        res.first.code_unit = point;
        res.first.last      = eos;
      end else begin
        res.has_second       = 1'b1;
        res.first.code_unit  = HIGH_SURR + {10'd0, supp[20:10]};
        res.second.code_unit = LOW_SURR + {11'd0, supp[9:0]};
        res.second.last      = eos;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      remain   <= '0;
      bad_cont <= 1'b0;
      discard  <= 1'b0;
    end else if (consume) begin
      acc      <= acc_next;
      remain   <= remain_next;
      bad_cont <= bad_cont_next;
      discard  <= discard_next;
    end
  end

endmodule

// File: hw/rtl/u8u16_out_buf.sv
// two-entry result register: holds a decoded word, or both halves of a
// surrogate pair, towards the receiver; depends on u8u16_pkg

module u8u16_out_buf import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  dec_res_t   res,
  output logic       can_load,
  output logic       unit_valid,
  input  logic       unit_stall,
  output unit_item_t unit_item
);

  logic       head_v, tail_v;
  unit_item_t head, tail;
  logic       pop;

  assign pop        = head_v && !unit_stall;
  assign can_load   = !head_v || (pop && !tail_v);
  assign unit_valid = head_v;
  assign unit_item  = head;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (load) begin
      head_v <= res.has_first;
      tail_v <= res.has_second;
    end else if (pop) begin
      head_v <= tail_v;
      tail_v <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      head <= res.first;
      tail <= res.second;
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

// File: tb/sv/tb_utf8_to_utf16_transcoder_core.sv
// self-checking testbench for the utf-8 to utf-16 / utf-32 transcoder core
// depends on u8u16_pkg and utf8_to_utf16_transcoder_core; byte words go in from a queue,
// result words are checked against an in-bench decoder as they leave

`timescale 1ns / 100ps

module tb_utf8_to_utf16_transcoder_core;
  import u8u16_pkg::*;

  // receiver stall styles
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_TOGGLE = 3;

  localparam int LONG_HOLD_CYCLES = 120;
  localparam int IDLE_LIMIT       = 4000;
  localparam int DRAIN_CYCLES     = 4;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       cfg_we     = 1'b0;
  logic       cfg_wdata  = 1'b0;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_item  = '0;
  logic       unit_valid;
  logic       unit_stall = 1'b0;
  unit_item_t unit_item;

  // words waiting to be offered, and result words still owed by the block
  byte_item_t pending_bytes[$];
  unit_item_t expected_units[$];

  // decoder copy: mode register and sequence state
  logic        out_mode      = MODE_UTF16;
  logic [20:0] acc_point     = '0;
  logic [1:0]  bytes_left    = '0;
  logic        bad_cont_seen = 1'b0;
  logic        dropping      = 1'b0;

  int mismatch_count = 0;
  int hold_asked     = 0;
  int burst_left     = 0;
  int gap_left       = 0;

  utf8_to_utf16_transcoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    $display("%0t  %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_sequence();
    acc_point     = '0;
    bytes_left    = '0;
    bad_cont_seen = 1'b0;
  endtask

  task automatic push_error(logic [1:0] code, logic eos);
    unit_item_t u;
    u.kind       = KIND_ERROR;
    u.code_unit  = '0;
    u.error_code = code;
    u.last       = 1'b1;
    expected_units.push_back(u);
    clear_sequence();
    dropping = !eos;
  endtask

  // code point out as one utf-32 word, one utf-16 word or a surrogate pair
  task automatic push_point(logic [20:0] cp, logic eos);
    unit_item_t  u;
    logic [20:0] offset;
    u.kind       = KIND_UNIT;
    u.error_code = '0;
    if (out_mode == MODE_UTF32 || cp <= 21'h0FFFF) begin
      u.code_unit = cp;
      u.last      = eos;
      expected_units.push_back(u);
    end else begin
      offset      = cp - SUPP_BASE;
      u.code_unit = (HIGH_SURR + (offset >> 10)) & 21'h0FFFF;
      u.last      = 1'b0;
      expected_units.push_back(u);
      u.code_unit = LOW_SURR + (offset & 21'h003FF);
      u.last      = eos;
      expected_units.push_back(u);
    end
  endtask

  // decoder step for one accepted byte word
  task automatic decode_byte(byte_item_t w);
    logic [7:0]  b;
    logic        eos;
    logic [20:0] cp;
    b   = w.data_byte;
    eos = w.end_of_string;
    if (dropping) begin
      if (eos) begin
        dropping = 1'b0;
        clear_sequence();
      end
      return;
    end
    if (bytes_left == 2'd0) begin
      if (b[7] == 1'b0) begin
        cp = {13'd0, b};
        clear_sequence();
        push_point(cp, eos);
      end else if (b[7:5] == 3'b110) begin
        acc_point  = {16'd0, b[4:0]};
        bytes_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_point  = {17'd0, b[3:0]};
        bytes_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_point  = {18'd0, b[2:0]};
        bytes_left = 2'd3;
      end else begin
        push_error(ERR_BAD_LEAD, eos);
        return;
      end
      bad_cont_seen = 1'b0;
      if (bytes_left != 2'd0 && eos)
        push_error(ERR_TRUNCATED, eos);
    end else begin
      // a malformed continuation is still consumed, the error waits for the end
      if (b[7:6] != 2'b10)
        bad_cont_seen = 1'b1;
      acc_point  = {acc_point[14:0], b[5:0]};
      bytes_left = bytes_left - 2'd1;
      if (bytes_left != 2'd0) begin
        if (eos)
          push_error(ERR_TRUNCATED, eos);
      end else if (bad_cont_seen) begin
        push_error(ERR_BAD_CONT, eos);
      end else begin
        cp = acc_point;
        clear_sequence();
        push_point(cp, eos);
      end
    end
  endtask

  task automatic add_byte(logic [7:0] b, logic eos);
    byte_item_t w;
    w.data_byte     = b;
    w.end_of_string = eos;
    pending_bytes.push_back(w);
  endtask

  // one string of well-formed characters, sometimes damaged
  task automatic add_random_string(output int len);
    logic [7:0] s[$];
    int         chars;
    int         n;
    int         flaw;
    int         cut;
    chars = $urandom_range(1, 6);
    repeat (chars) begin
      n = $urandom_range(1, 4);
      case (n)
        1: s.push_back({1'b0, 7'($urandom)});
        2: s.push_back({3'b110, 5'($urandom)});
        3: s.push_back({4'b1110, 4'($urandom)});
        default: s.push_back({5'b11110, 3'($urandom)});
      endcase
      repeat (n - 1) s.push_back({2'b10, 6'($urandom)});
    end
    flaw = $urandom_range(0, 9);
    case (flaw)
      0: s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
      1: begin
        if (s.size() > 1) begin
          cut = $urandom_range(1, s.size() - 1);
          repeat (cut) void'(s.pop_back());
        end
      end
      2: begin
        s[$urandom_range(0, s.size() - 1)] = $urandom_range(0, 1) ?
          8'($urandom_range(8'h80, 8'hBF)) : 8'($urandom_range(8'hF8, 8'hFF));
      end
      3: begin
        s.delete();
        repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
      end
      default: ;
    endcase
    foreach (s[k])
      add_byte(s[k], k == s.size() - 1);
    len = s.size();
  endtask

  // settled at the falling edge: nothing queued, offered or owed
  task automatic wait_idle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || byte_valid || expected_units.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    out_mode = m;
  endtask

  task automatic run_random_phase(int target, bit long_hold);
    int made;
    int len;
    made = 0;
    @(negedge clk);
    if (long_hold)
      hold_asked++;
    while (made < target) begin
      add_random_string(len);
      made += len;
    end
    wait_idle();
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // byte word sender: bursts with random gaps, decoder runs on acceptance
  always @(posedge clk) begin : byte_driver
    logic offer;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      offer = byte_valid;
      if (byte_valid && !byte_stall) begin
        decode_byte(byte_item);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          byte_item <= pending_bytes.pop_front();
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      byte_valid <= offer;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin : unit_receiver
    int hold_served;
    int hold_left;
    int style;
    int style_left;
    if (rst) begin
      unit_stall  <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
      style       = STALL_NONE;
      style_left  = 0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        unit_stall <= 1'b1;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(STALL_NONE, STALL_TOGGLE);
          style_left = $urandom_range(16, 96);
        end else begin
          style_left--;
        end
        case (style)
          STALL_NONE:  unit_stall <= 1'b0;
          STALL_LIGHT: unit_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: unit_stall <= ($urandom_range(0, 3) != 0);
          default:     unit_stall <= !unit_stall;
        endcase
      end
    end
  end

  // result word checker
  always @(posedge clk) begin : unit_monitor
    unit_item_t want;
    if (!rst && unit_valid && !unit_stall) begin
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("unexpected word 0x%0h", unit_item));
      end else begin
        want = expected_units.pop_front();
        check_field("kind", unit_item.kind, want.kind);
        check_field("code_unit", unit_item.code_unit, want.code_unit);
        check_field("error_code", unit_item.error_code, want.error_code);
        check_field("last", unit_item.last, want.last);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (byte_valid && !byte_stall) || (unit_valid && !unit_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("utf8_to_utf16_transcoder_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_mode(MODE_UTF16);

    // directed strings in utf-16 mode
    @(negedge clk);
    add_byte(8'h00, 1'b1);
    add_byte(8'h7F, 1'b1);
    // two, three and four byte characters, the last giving a surrogate pair
    add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b1);
    // largest value a four byte form can carry, beyond the unicode range
    add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    // bad lead mid-string, rest dropped up to the end flag
    add_byte(8'h80, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b1);
    // bad lead on the final byte
    add_byte(8'hFF, 1'b1);
    // truncation, and truncation winning over a bad continuation
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
    add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b1);
    // bad continuation reported when the sequence completes
    add_byte(8'hC3, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h41, 1'b1);
    wait_idle();

    write_mode(MODE_UTF32);
    run_random_phase(300, 1'b1);
    write_mode(MODE_UTF16);
    run_random_phase(300, 1'b0);
    write_mode(MODE_UTF32);
    run_random_phase(150, 1'b0);
    write_mode(MODE_UTF16);
    run_random_phase(150, 1'b1);

    repeat (8) @(posedge clk);
    if (expected_units.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_units.size()));
    if (mismatch_count == 0)
      $display("utf8_to_utf16_transcoder_core: match");
    else
      $display("utf8_to_utf16_transcoder_core: mismatch");
    $finish;
  end

endmodule
